// ===== hw/rtl/obbpt_pkg.sv =====
// Shared types and constants for the order book best price tracker.
// Used by obbpt_cell and order_book_best_price_tracker_core; no dependencies.
package obbpt_pkg;

	localparam int LVL_W        = 10;
	localparam int QTY_W        = 32;
	localparam int LVL_SPAN     = 1 << LVL_W;
	localparam int PRICE_LEVELS_DEF = 1024;
	localparam int CHAIN_TARGET = 8;

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef struct packed {
		logic             side;
		logic [LVL_W-1:0] level;
		logic [QTY_W-1:0] quantity;
	} req_t;

	typedef struct packed {
		logic             bid_valid;
		logic [LVL_W-1:0] best_bid;
		logic             ask_valid;
		logic [LVL_W-1:0] best_ask;
		logic             uncrossed;
	} rsp_t;

	// Write of one occupancy bit into the cell row.
	typedef struct packed {
		logic             en;
		logic             side;
		logic [LVL_W-1:0] level;
		logic             set;
	} cell_wr_t;

	// Best occupied level seen so far along the row.
	typedef struct packed {
		logic             found;
		logic [LVL_W-1:0] lvl;
	} lvl_sum_t;

endpackage

// ===== hw/rtl/order_book_best_price_tracker_core.sv =====
// Top level of the order book best price tracker: request sequencer and cell row.
// Depends on obbpt_pkg and obbpt_cell.
//
// Each request carries a side, a price level and a quantity and yields one response
// with both best prices, their valid flags and the uncrossed flag. Only whether a
// level holds quantity matters, so the book is kept as one occupancy bit per level
// and side, spread over a row of cells. Each cell registers the best occupied level
// of its own slice or, if its slice is empty, the value handed in by its neighbor:
// bids flow toward higher levels, asks toward lower ones. A request that does not
// remove the current best level goes through the update and emit steps to its
// response. When it removes the best, a search step first waits for the row to
// settle across all cells (8 cells at the default window).
// One request is in work at a time; a finished response waits in the output register
// while the next request is taken. Levels at or above the window are ignored and the
// response shows the unchanged book. Reset clears the whole book at once.
module order_book_best_price_tracker_core import obbpt_pkg::*; #(
	parameter int PRICE_LEVELS = PRICE_LEVELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int TRACKED   = (PRICE_LEVELS < LVL_SPAN) ? PRICE_LEVELS : LVL_SPAN;
	localparam int RAW_BITS  = (TRACKED + CHAIN_TARGET - 1) / CHAIN_TARGET;
	localparam int POW_BITS  = 1 << $clog2(RAW_BITS);
	localparam int CELL_BITS = (POW_BITS < 2) ? 2 : POW_BITS;
	localparam int CELLS     = (TRACKED + CELL_BITS - 1) / CELL_BITS;
	localparam int CNT_W     = $clog2(CELLS + 1);

	typedef enum logic [1:0] {S_IDLE, S_UPD, S_SEARCH, S_EMIT} state_t;

	state_t           state_q;
	req_t             req_s1;
	logic [CNT_W-1:0] cnt_q;
	logic             search_side_q;
	logic [LVL_W-1:0] best_bid_q;
	logic [LVL_W-1:0] best_ask_q;
	logic             bid_present_q;
	logic             ask_present_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             lvl_ok;
	logic             nz;
	cell_wr_t         wr;
	lvl_sum_t         bid_link [CELLS];
	lvl_sum_t         ask_link [CELLS];
	lvl_sum_t         none;

	assign none   = '0;
	assign lvl_ok = ({1'b0, req_s1.level} < (LVL_W+1)'(TRACKED));
	assign nz     = |req_s1.quantity;

	// Write the occupancy bit during the update step only.
	assign wr = '{en: (state_q == S_UPD) && lvl_ok, side: req_s1.side,
		level: req_s1.level, set: nz};

	genvar g;
	generate
		for (g = 0; g < CELLS; g++) begin : g_cell
			lvl_sum_t bid_in;
			lvl_sum_t ask_in;
			if (g == 0) begin : g_lo
				assign bid_in = none;
			end else begin : g_lo_link
				assign bid_in = bid_link[g-1];
			end
			if (g == CELLS - 1) begin : g_hi
				assign ask_in = none;
			end else begin : g_hi_link
				assign ask_in = ask_link[g+1];
			end
			obbpt_cell #(
				.CELL_BITS(CELL_BITS),
				.CELL_IDX (g)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.wr     (wr),
				.bid_in (bid_in),
				.ask_in (ask_in),
				.bid_out(bid_link[g]),
				.ask_out(ask_link[g])
			);
		end
	endgenerate

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			req_s1        <= '0;
			cnt_q         <= '0;
			search_side_q <= SIDE_BID;
			best_bid_q    <= '0;
			best_ask_q    <= '0;
			bid_present_q <= 1'b0;
			ask_present_q <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			// Drop the response once the far side takes it.
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_s1  <= req;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= S_EMIT;
					if (lvl_ok && req_s1.side == SIDE_BID) begin
						if (nz && (!bid_present_q || req_s1.level > best_bid_q)) begin
							best_bid_q    <= req_s1.level;
							bid_present_q <= 1'b1;
						end else if (!nz && bid_present_q && req_s1.level == best_bid_q) begin
							search_side_q <= SIDE_BID;
							cnt_q         <= CNT_W'(CELLS);
							state_q       <= S_SEARCH;
						end
					end
					if (lvl_ok && req_s1.side == SIDE_ASK) begin
						if (nz && (!ask_present_q || req_s1.level < best_ask_q)) begin
							best_ask_q    <= req_s1.level;
							ask_present_q <= 1'b1;
						end else if (!nz && ask_present_q && req_s1.level == best_ask_q) begin
							search_side_q <= SIDE_ASK;
							cnt_q         <= CNT_W'(CELLS);
							state_q       <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					// Hold until the cleared bit has swept the full row.
					if (cnt_q == '0) begin
						state_q <= S_EMIT;
						if (search_side_q == SIDE_BID) begin
							bid_present_q <= bid_link[CELLS-1].found;
							best_bid_q    <= bid_link[CELLS-1].found ?
								bid_link[CELLS-1].lvl : '0;
						end else begin
							ask_present_q <= ask_link[0].found;
							best_ask_q    <= ask_link[0].found ? ask_link[0].lvl : '0;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_EMIT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.bid_valid <= bid_present_q;
						rsp_q.best_bid  <= bid_present_q ? best_bid_q : '0;
						rsp_q.ask_valid <= ask_present_q;
						rsp_q.best_ask  <= ask_present_q ? best_ask_q : '0;
						rsp_q.uncrossed <= !bid_present_q || !ask_present_q ||
							(best_bid_q < best_ask_q);
						rsp_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_bid_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!bid_present_q |-> best_bid_q == '0)
		else $error("best bid nonzero on empty bid side");

	a_ask_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!ask_present_q |-> best_ask_q == '0)
		else $error("best ask nonzero on empty ask side");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && (!rsp_valid_q || !rsp_stall)) |=> rsp_valid_q)
		else $error("response not loaded on emit");

	a_search_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_SEARCH) |-> $past(state_q) == S_UPD)
		else $error("search entered outside update step");

endmodule

// ===== hw/rtl/obbpt_cell.sv =====
// One cell of the occupancy row: holds the bid and ask bits of a slice of levels.
// Depends on obbpt_pkg; instantiated by order_book_best_price_tracker_core.
module obbpt_cell import obbpt_pkg::*; #(
	parameter int CELL_BITS = 128,
	parameter int CELL_IDX  = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cell_wr_t wr,
	input  lvl_sum_t bid_in,
	input  lvl_sum_t ask_in,
	output lvl_sum_t bid_out,
	output lvl_sum_t ask_out
);

	localparam int OFF_W = $clog2(CELL_BITS);

	logic [CELL_BITS-1:0] bid_bits_q;
	logic [CELL_BITS-1:0] ask_bits_q;
	lvl_sum_t             bid_stage_q;
	lvl_sum_t             ask_stage_q;
	logic                 hit;
	logic [OFF_W-1:0]     off;
	logic [OFF_W-1:0]     hi_off;
	logic [OFF_W-1:0]     lo_off;
	logic [LVL_W-1:0]     base;

	assign base = LVL_W'(CELL_IDX) << OFF_W;
	assign off  = wr.level[OFF_W-1:0];
	assign hit  = wr.en && ((wr.level >> OFF_W) == LVL_W'(CELL_IDX));

	// Highest occupied bid bit and lowest occupied ask bit in this slice.
	always_comb begin
		hi_off = '0;
		lo_off = '0;
		for (int i = 0; i < CELL_BITS; i++) begin
			if (bid_bits_q[i]) hi_off = OFF_W'(i);
		end
		for (int i = CELL_BITS - 1; i >= 0; i--) begin
			if (ask_bits_q[i]) lo_off = OFF_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_bits_q  <= '0;
			ask_bits_q  <= '0;
			bid_stage_q <= '0;
			ask_stage_q <= '0;
		end else begin
			if (hit && wr.side == SIDE_BID) bid_bits_q[off] <= wr.set;
			if (hit && wr.side == SIDE_ASK) ask_bits_q[off] <= wr.set;
			// Take the local best if the slice is occupied, else pass the neighbor on.
			if (|bid_bits_q) begin
				bid_stage_q <= '{found: 1'b1, lvl: base | LVL_W'(hi_off)};
			end else begin
				bid_stage_q <= bid_in;
			end
			if (|ask_bits_q) begin
				ask_stage_q <= '{found: 1'b1, lvl: base | LVL_W'(lo_off)};
			end else begin
				ask_stage_q <= ask_in;
			end
		end
	end

	assign bid_out = bid_stage_q;
	assign ask_out = ask_stage_q;

endmodule

// ===== test/order_book_best_price_tracker_core_test.sv =====
// Self-checking testbench for order_book_best_price_tracker_core.
// Depends on obbpt_pkg; drives random and directed level updates and checks every response
// against a behavioral top-of-book predictor held in a small scoreboard class.

module order_book_best_price_tracker_core_test;
	import obbpt_pkg::*;

	// Behavioral book: full quantity tables and the tracked best levels.
	class book_scoreboard;
		logic [QTY_W-1:0] bid_qty [LVL_SPAN];
		logic [QTY_W-1:0] ask_qty [LVL_SPAN];
		logic [LVL_W-1:0] top_bid, top_ask;
		logic             has_bid, has_ask;
		rsp_t             pending [$];
		int               errors;
		int               checked;

		function new();
			for (int i = 0; i < LVL_SPAN; i++) begin
				bid_qty[i] = '0;
				ask_qty[i] = '0;
			end
			top_bid = '0;
			top_ask = '0;
			has_bid = 1'b0;
			has_ask = 1'b0;
			errors  = 0;
			checked = 0;
		endfunction

		// Apply one accepted request to the book and queue the expected response.
		function void note_request(req_t r);
			rsp_t e;
			if (r.level < PRICE_LEVELS_DEF) begin
				if (r.side == SIDE_BID) begin
					bid_qty[r.level] = r.quantity;
					if (r.quantity != 0 && (!has_bid || r.level > top_bid)) begin
						top_bid = r.level;
						has_bid = 1'b1;
					end else if (r.quantity == 0 && has_bid && r.level == top_bid) begin
						has_bid = 1'b0;
						top_bid = '0;
						for (int i = PRICE_LEVELS_DEF - 1; i >= 0; i--)
							if (!has_bid && bid_qty[i] != 0) begin
								has_bid = 1'b1;
								top_bid = i[LVL_W-1:0];
							end
					end
				end else begin
					ask_qty[r.level] = r.quantity;
					if (r.quantity != 0 && (!has_ask || r.level < top_ask)) begin
						top_ask = r.level;
						has_ask = 1'b1;
					end else if (r.quantity == 0 && has_ask && r.level == top_ask) begin
						has_ask = 1'b0;
						top_ask = '0;
						for (int i = 0; i < PRICE_LEVELS_DEF; i++)
							if (!has_ask && ask_qty[i] != 0) begin
								has_ask = 1'b1;
								top_ask = i[LVL_W-1:0];
							end
					end
				end
			end
			e.bid_valid = has_bid;
			e.best_bid  = has_bid ? top_bid : '0;
			e.ask_valid = has_ask;
			e.best_ask  = has_ask ? top_ask : '0;
			e.uncrossed = !has_bid || !has_ask || (top_bid < top_ask);
			pending.push_back(e);
		endfunction

		// Compare one accepted response with the oldest expectation.
		function void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected response %p", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (a.bid_valid !== e.bid_valid) begin
				$error("bid_valid exp %0d got %0d", e.bid_valid, a.bid_valid);
				errors++;
			end
			if (a.best_bid !== e.best_bid) begin
				$error("best_bid exp %0d got %0d", e.best_bid, a.best_bid);
				errors++;
			end
			if (a.ask_valid !== e.ask_valid) begin
				$error("ask_valid exp %0d got %0d", e.ask_valid, a.ask_valid);
				errors++;
			end
			if (a.best_ask !== e.best_ask) begin
				$error("best_ask exp %0d got %0d", e.best_ask, a.best_ask);
				errors++;
			end
			if (a.uncrossed !== e.uncrossed) begin
				$error("uncrossed exp %0d got %0d", e.uncrossed, a.uncrossed);
				errors++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	book_scoreboard book = new();
	int send_idle_pct = 0;   // chance in percent that the sender holds off a cycle
	int recv_stall_pct = 0;  // chance in percent that the receiver stalls a cycle
	int cycles = 0;
	int sent = 0;

	order_book_best_price_tracker_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// Sample both handshakes at the rising edge; the class keeps order.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && req_valid && !req_stall)
			book.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			book.check_response(rsp);
		if (cycles > CYCLE_LIMIT) begin
			$display("order_book_best_price_tracker_core_test NOT OK");
			$finish;
		end
	end

	// Drive the receiver stall at the falling edge.
	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);

	// Present one request, idling at random first, and hold it until accepted.
	task automatic send_request(logic s, logic [LVL_W-1:0] l, logic [QTY_W-1:0] q);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= '{side: s, level: l, quantity: q};
		do @(posedge clk); while (req_stall);
		sent++;
	endtask

	// Drop valid and wait until every expected response has arrived.
	task automatic drain_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (book.pending.size() != 0) @(posedge clk);
	endtask

	// Random quantity: mostly small, sometimes zero, sometimes the full range.
	function automatic logic [QTY_W-1:0] pick_quantity();
		int r;
		r = $urandom_range(99);
		if (r < 35) return '0;
		if (r < 85) return QTY_W'($urandom_range(1, 500));
		return QTY_W'($urandom());
	endfunction

	// Random level: clustered near the book so deletes often hit the best.
	function automatic logic [LVL_W-1:0] pick_level();
		int r;
		r = $urandom_range(99);
		if (r < 60) return LVL_W'($urandom_range(480, 540));
		if (r < 70) return (r < 65) ? '0 : '1;
		return LVL_W'($urandom());
	endfunction

	task automatic random_phase(int n);
		logic s;
		logic [LVL_W-1:0] l;
		for (int i = 0; i < n; i++) begin
			s = 1'($urandom_range(1));
			l = pick_level();
			// Delete the current best often to exercise the search path.
			if ($urandom_range(99) < 20) begin
				if (s == SIDE_BID && book.has_bid) l = book.top_bid;
				if (s == SIDE_ASK && book.has_ask) l = book.top_ask;
				send_request(s, l, '0);
			end else
				send_request(s, l, pick_quantity());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty deletes, extremes of level and quantity, bettering,
		// behind-best updates, best deletion with and without a fallback.
		send_request(SIDE_BID, 10'd5, '0);
		send_request(SIDE_ASK, 10'd5, '0);
		send_request(SIDE_BID, 10'd0, 32'd1);
		send_request(SIDE_ASK, 10'd1023, 32'hFFFF_FFFF);
		send_request(SIDE_BID, 10'd1023, 32'h8000_0000);
		send_request(SIDE_ASK, 10'd0, 32'd7);
		send_request(SIDE_BID, 10'd100, 32'd3);
		send_request(SIDE_ASK, 10'd900, 32'd3);
		send_request(SIDE_BID, 10'd1023, '0);
		send_request(SIDE_ASK, 10'd0, '0);
		send_request(SIDE_BID, 10'd50, '0);
		send_request(SIDE_BID, 10'd100, '0);
		send_request(SIDE_BID, 10'd0, '0);
		send_request(SIDE_ASK, 10'd900, '0);
		send_request(SIDE_ASK, 10'd1023, '0);
		send_request(SIDE_BID, 10'd600, 32'h5555_5555);
		send_request(SIDE_ASK, 10'd600, 32'hAAAA_AAAA);
		send_request(SIDE_ASK, 10'd599, 32'd2);
		send_request(SIDE_BID, 10'd600, '0);
		send_request(SIDE_ASK, 10'd599, '0);
		send_request(SIDE_ASK, 10'd600, '0);

		// Hold off until the book has answered everything.
		drain_responses();

		send_idle_pct = 21; recv_stall_pct = 81;
		random_phase(150);
		send_idle_pct = 81; recv_stall_pct = 21;
		random_phase(150);
		send_idle_pct = 0; recv_stall_pct = 0;
		random_phase(150);

		drain_responses();
		repeat (30) @(posedge clk);
		$display("Sent %0d level updates, checked %0d top-of-book responses,", sent,
			book.checked);
		$display("covering best deletion searches, both sides and three idle mixes.");
		if (book.errors == 0 && book.pending.size() == 0)
			$display("order_book_best_price_tracker_core_test OK");
		else
			$display("order_book_best_price_tracker_core_test NOT OK");
		$finish;
	end

endmodule

// ===== order_book_best_price_tracker_core.f =====
hw/rtl/obbpt_pkg.sv
hw/rtl/obbpt_cell.sv
hw/rtl/order_book_best_price_tracker_core.sv
test/order_book_best_price_tracker_core_test.sv
